>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL. They compile to nothing
// when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define AID_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The expression must never be true outside reset.
`define AID_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define AID_ASSERT(lbl, clk, rst_n, prop, msg)
`define AID_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

>>> sv/aid_pkg.sv
// ---------------------------------------------------------------------------
// aid_pkg
// Shared widths and default depths for the distinct array intersection block.
// ---------------------------------------------------------------------------
package aid_pkg;

    // Width of one list element.
    localparam int VALUE_W = 32;

    // Width of the reported running count of common elements.
    localparam int TOTAL_W = 9;

    // Default store depths.
    localparam int AID_LIST_DEPTH   = 256;
    localparam int AID_COMMON_DEPTH = 256;

    // Operation codes of an input request.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PROBE = 1'b1;

endpackage

>>> sv/aid_ram.sv
// ---------------------------------------------------------------------------
// aid_ram
// Simple dual-port memory: one write port and one read port with a
// registered read, so data appears in the cycle after the address.
// ---------------------------------------------------------------------------
module aid_ram import aid_pkg::*; #(
    parameter int DEPTH = AID_LIST_DEPTH,
    parameter int WIDTH = VALUE_W
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/array_intersection_distinct.sv
// ---------------------------------------------------------------------------
// array_intersection_distinct: distinct common elements of two integer lists.
// A load goes straight to commit; a probe scans the common store and, on a miss there,
// the second-list store. A new request is taken only once the last result is committed.
// Reset clears counts.
// ---------------------------------------------------------------------------
module array_intersection_distinct import aid_pkg::*; #(
    parameter int LIST_DEPTH   = AID_LIST_DEPTH,
    parameter int COMMON_DEPTH = AID_COMMON_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Input request channel.
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_op,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_last,
    // Result channel.
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_emitted,
    output logic signed [VALUE_W-1:0] o_common_value,
    output logic [TOTAL_W-1:0]        o_common_total,
    output logic                      o_finished,
    output logic                      o_store_full
);

`include "assert_macros.svh"

    localparam int LAW = $clog2(LIST_DEPTH);
    localparam int LCW = $clog2(LIST_DEPTH + 1);
    localparam int CAW = $clog2(COMMON_DEPTH);
    localparam int CCW = $clog2(COMMON_DEPTH + 1);
    localparam int SW  = (LCW > CCW) ? LCW : CCW;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN_C = 2'd1;
    localparam logic [1:0] S_SCAN_S = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    // Control registers.
    logic [1:0]     r_state, n_state;
    logic [SW-1:0]  r_addr, n_addr;
    logic           r_pend, n_pend;
    logic           r_emit, n_emit;
    logic [LCW-1:0] r_scount, n_scount;
    logic [CCW-1:0] r_ccount, n_ccount;
    logic           r_out_valid;

    // Request payload held while it is processed.
    logic               r_op;
    logic [VALUE_W-1:0] r_value;
    logic               r_last;

    // Result payload registers.
    logic               r_emitted;
    logic [VALUE_W-1:0] r_common_value;
    logic [TOTAL_W-1:0] r_common_total;
    logic               r_finished;
    logic               r_store_full;

    // Memory ports.
    logic               s_rd_en, c_rd_en;
    logic               s_wr_en, c_wr_en;
    logic [VALUE_W-1:0] s_rd_data, c_rd_data;

    logic          in_acc, slot_free, commit;
    logic          s_full, c_full;
    logic          c_hit, s_hit, c_more, s_more;
    logic [SW-1:0] s_cnt_ext, c_cnt_ext;
    logic [CCW-1:0] ccount_upd;

    // Second-list store.
    aid_ram #(
        .DEPTH (LIST_DEPTH),
        .WIDTH (VALUE_W)
    ) u_second_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s_wr_en),
        .i_wr_addr (r_scount[LAW-1:0]),
        .i_wr_data (r_value),
        .i_rd_en   (s_rd_en),
        .i_rd_addr (r_addr[LAW-1:0]),
        .o_rd_data (s_rd_data)
    );

    // Store of common elements already emitted.
    aid_ram #(
        .DEPTH (COMMON_DEPTH),
        .WIDTH (VALUE_W)
    ) u_common_ram (
        .i_clk     (i_clk),
        .i_wr_en   (c_wr_en),
        .i_wr_addr (r_ccount[CAW-1:0]),
        .i_wr_data (r_value),
        .i_rd_en   (c_rd_en),
        .i_rd_addr (r_addr[CAW-1:0]),
        .o_rd_data (c_rd_data)
    );

    // Handshake and scan status.
    assign in_acc    = i_valid && (r_state == S_IDLE);
    assign slot_free = !r_out_valid || !i_stall;
    assign commit    = (r_state == S_DONE) && slot_free;
    assign s_full    = (r_scount == LCW'(LIST_DEPTH));
    assign c_full    = (r_ccount == CCW'(COMMON_DEPTH));
    assign s_cnt_ext = SW'(r_scount);
    assign c_cnt_ext = SW'(r_ccount);
    assign c_more    = (r_addr < c_cnt_ext);
    assign s_more    = (r_addr < s_cnt_ext);
    assign c_hit     = r_pend && (c_rd_data == r_value);
    assign s_hit     = r_pend && (s_rd_data == r_value);
    assign c_rd_en   = (r_state == S_SCAN_C) && c_more && !c_hit;
    assign s_rd_en   = (r_state == S_SCAN_S) && s_more && !s_hit;

    // Memory writes happen only when the result is committed.
    assign s_wr_en    = commit && (r_op == OP_LOAD) && !s_full;
    assign c_wr_en    = commit && (r_op == OP_PROBE) && r_emit;
    assign ccount_upd = r_ccount + CCW'(c_wr_en);

    // Sequencer: a probe scans the common store, then on a miss the second-list store.
    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_pend   = 1'b0;
        n_emit   = r_emit;
        n_scount = r_scount;
        n_ccount = r_ccount;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_addr  = '0;
                    n_emit  = 1'b0;
                    n_state = (i_op == OP_PROBE) ? S_SCAN_C : S_DONE;
                end
            end
            S_SCAN_C: begin
                if (c_hit) begin
                    n_state = S_DONE;
                end else if (!c_more && !r_pend) begin
                    n_addr  = '0;
                    n_state = S_SCAN_S;
                end else if (c_rd_en) begin
                    n_addr = r_addr + SW'(1);
                    n_pend = 1'b1;
                end
            end
            S_SCAN_S: begin
                if (s_hit) begin
                    n_emit  = !c_full;
                    n_state = S_DONE;
                end else if (!s_more && !r_pend) begin
                    n_state = S_DONE;
                end else if (s_rd_en) begin
                    n_addr = r_addr + SW'(1);
                    n_pend = 1'b1;
                end
            end
            S_DONE: begin
                if (commit) begin
                    n_state = S_IDLE;
                    if ((r_op == OP_PROBE) && r_last) begin
                        n_scount = '0;
                        n_ccount = '0;
                    end else begin
                        n_scount = r_scount + LCW'(s_wr_en);
                        n_ccount = ccount_upd;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_emit      <= 1'b0;
            r_scount    <= '0;
            r_ccount    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_pend   <= n_pend;
            r_emit   <= n_emit;
            r_scount <= n_scount;
            r_ccount <= n_ccount;
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the request payload.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op    <= i_op;
            r_value <= i_value;
            r_last  <= i_last;
        end
    end

    // Result register; loaded only when the slot is free.
    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_emitted      <= c_wr_en;
            r_common_value <= c_wr_en ? r_value : '0;
            r_common_total <= TOTAL_W'(ccount_upd);
            r_finished     <= (r_op == OP_PROBE) && r_last;
            r_store_full   <= (r_op == OP_LOAD) && s_full;
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_emitted      = r_emitted;
    assign o_common_value = r_common_value;
    assign o_common_total = r_common_total;
    assign o_finished     = r_finished;
    assign o_store_full   = r_store_full;

    // The second count never runs past its store depth.
    `AID_ASSERT(a_scount_range, i_clk, i_rst_n, r_scount <= LCW'(LIST_DEPTH), "second count overflow")
    // A dropped load never emits and never finishes a problem.
    `AID_ASSERT(a_full_result, i_clk, i_rst_n, !(o_valid && o_store_full) || (!o_emitted && !o_finished), "bad full result")
    // An emitted element advances the common count by one unless the problem ends.
    `AID_ASSERT(a_emit_count, i_clk, i_rst_n, (c_wr_en && !r_last) |=> (r_ccount == $past(ccount_upd)), "common count slip")
    // The memories are never read outside a scan.
    `AID_ASSERT_NEVER(a_rd_idle, i_clk, i_rst_n, (s_rd_en || c_rd_en) && ((r_state == S_IDLE) || (r_state == S_DONE)), "read outside scan")

endmodule

>>> tb/tb_array_intersection_distinct.sv
// ---------------------------------------------------------------------------
// tb_array_intersection_distinct: self-checking bench for the distinct
// array intersection block.
// Requests are driven on the falling edge with random gaps, and results are
// taken on the rising edge under random stalls. A local model of both stores
// predicts every result, and each result is checked field by field against
// the oldest prediction.
// ---------------------------------------------------------------------------
module tb_array_intersection_distinct import aid_pkg::*; ();

    localparam int LIST_DEPTH   = AID_LIST_DEPTH;
    localparam int COMMON_DEPTH = AID_COMMON_DEPTH;
    // Cycles with no request or result accepted before the run is abandoned.
    localparam int STALL_LIMIT  = 4000;
    // Quiet cycles after the last result, a little over the longest probe.
    localparam int DRAIN_CYCLES = COMMON_DEPTH + LIST_DEPTH + 16;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic               emitted;
        logic [VALUE_W-1:0] common_value;
        logic [TOTAL_W-1:0] common_total;
        logic               finished;
        logic               store_full;
    } t_result;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic                      i_op;
    logic signed [VALUE_W-1:0] i_value;
    logic                      i_last;
    logic                      o_valid;
    logic                      i_stall;
    logic                      o_emitted;
    logic signed [VALUE_W-1:0] o_common_value;
    logic [TOTAL_W-1:0]        o_common_total;
    logic                      o_finished;
    logic                      o_store_full;

    array_intersection_distinct uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_value        (i_value),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_emitted      (o_emitted),
        .o_common_value (o_common_value),
        .o_common_total (o_common_total),
        .o_finished     (o_finished),
        .o_store_full   (o_store_full)
    );

    // Local copy of the two stores and their counts.
    logic [VALUE_W-1:0] list_store [LIST_DEPTH];
    logic [VALUE_W-1:0] common_store [COMMON_DEPTH];
    int                 list_count;
    int                 common_count;

    t_result pending_results [$];
    int      mismatch_count;

    // Idle controls shared by the driving processes.
    bit sender_idle;
    bit receiver_idle;
    int recv_wait;
    int hold_request;
    int hold_left;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Work out the result of one request and advance the local stores.
    function automatic t_result predict_intersection(logic op, logic [VALUE_W-1:0] value,
                                                     logic last);
        t_result r;
        bit      seen;
        bit      listed;
        r      = '0;
        seen   = 1'b0;
        listed = 1'b0;
        if (op == OP_LOAD) begin
            if (list_count < LIST_DEPTH) begin
                list_store[list_count] = value;
                list_count++;
            end else begin
                r.store_full = 1'b1;
            end
        end else begin
            for (int k = 0; k < common_count; k++)
                if (common_store[k] == value) seen = 1'b1;
            for (int k = 0; k < list_count; k++)
                if (list_store[k] == value) listed = 1'b1;
            if (!seen && listed && common_count < COMMON_DEPTH) begin
                common_store[common_count] = value;
                common_count++;
                r.emitted      = 1'b1;
                r.common_value = value;
            end
            r.finished = last;
        end
        r.common_total = TOTAL_W'(common_count);
        // The last probe closes the problem and empties both stores.
        if (r.finished) begin
            list_count   = 0;
            common_count = 0;
        end
        return r;
    endfunction

    // Offer one request after a random gap and record its prediction once accepted.
    task automatic send_request(logic op, logic [VALUE_W-1:0] value, logic last);
        int gap;
        gap = sender_idle ? $urandom_range(0, 9) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_value <= value;
        i_last  <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(predict_intersection(op, value, last));
    endtask

    // Result stall: a random wait per result, plus the long hold-off on request.
    initial begin
        i_stall   = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (recv_wait > 0) begin
                recv_wait--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Compare each accepted result with the oldest prediction.
    initial begin
        t_result got;
        t_result want;
        bit      bad;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got = '{o_emitted, o_common_value, o_common_total, o_finished, o_store_full};
                recv_wait = receiver_idle ? $urandom_range(0, 9) : 0;
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: emitted=%0d value=%0d total=%0d fin=%0d full=%0d",
                                 got.emitted, $signed(got.common_value), got.common_total,
                                 got.finished, got.store_full);
                end else begin
                    want = pending_results.pop_front();
                    bad  = (got.emitted !== want.emitted) ||
                           (got.common_value !== want.common_value) ||
                           (got.common_total !== want.common_total) ||
                           (got.finished !== want.finished) ||
                           (got.store_full !== want.store_full);
                    if (bad) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp emitted=%0d value=%0d total=%0d fin=%0d full=%0d, got emitted=%0d value=%0d total=%0d fin=%0d full=%0d",
                                     want.emitted, $signed(want.common_value),
                                     want.common_total, want.finished, want.store_full,
                                     got.emitted, $signed(got.common_value),
                                     got.common_total, got.finished, got.store_full);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no progress on either channel.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Extremes, duplicates, a last flag on a load and probes on empty stores.
    task automatic test_directed();
        send_request(OP_PROBE, 32'd9, 1'b1);
        send_request(OP_LOAD, 32'h8000_0000, 1'b0);
        send_request(OP_LOAD, 32'h7fff_ffff, 1'b0);
        send_request(OP_LOAD, 32'h0000_0000, 1'b0);
        send_request(OP_LOAD, 32'hffff_ffff, 1'b1);
        send_request(OP_LOAD, 32'd5, 1'b0);
        send_request(OP_LOAD, 32'd5, 1'b0);
        send_request(OP_PROBE, 32'd7, 1'b0);
        send_request(OP_PROBE, 32'h7fff_ffff, 1'b0);
        send_request(OP_PROBE, 32'h7fff_ffff, 1'b0);
        send_request(OP_PROBE, 32'h8000_0000, 1'b0);
        send_request(OP_PROBE, 32'd5, 1'b0);
        send_request(OP_PROBE, 32'hffff_ffff, 1'b0);
        send_request(OP_PROBE, 32'h0000_0000, 1'b0);
        send_request(OP_PROBE, 32'd1, 1'b1);
        send_request(OP_PROBE, 32'd5, 1'b1);
    endtask

    // Fill the list store past its depth, then find every entry once.
    task automatic test_full_stores();
        logic [VALUE_W-1:0] loaded [LIST_DEPTH];
        int                 order [LIST_DEPTH];
        int                 j;
        int                 t;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            loaded[i] = {24'($urandom_range(0, 24'hff_ffff)), i[7:0]};
            order[i]  = i;
            send_request(OP_LOAD, loaded[i], 1'b0);
        end
        // Two loads past the depth are dropped.
        send_request(OP_LOAD, $urandom, 1'b0);
        send_request(OP_LOAD, loaded[0] ^ 32'h0000_0100, 1'b0);
        for (int i = LIST_DEPTH - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        send_request(OP_PROBE, loaded[0] ^ 32'h0000_0100, 1'b0);
        for (int i = 0; i < LIST_DEPTH; i++) begin
            send_request(OP_PROBE, loaded[order[i]], 1'b0);
            if (i == 10) send_request(OP_PROBE, loaded[order[3]], 1'b0);
        end
        send_request(OP_PROBE, loaded[order[0]], 1'b1);
    endtask

    // Hold results back for a long stretch while requests keep coming.
    task automatic test_backpressure();
        sender_idle  = 1'b0;
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 12; i++)
            send_request(OP_LOAD, $urandom_range(0, 7), 1'b0);
        for (int i = 0; i < 15; i++)
            send_request(OP_PROBE, $urandom_range(0, 9), i == 14);
        sender_idle = 1'b1;
    endtask

    // Many small problems drawn from a per-problem value pool.
    task automatic test_random();
        logic [VALUE_W-1:0] pool [8];
        logic [VALUE_W-1:0] value;
        int                 n_loads;
        int                 n_probes;
        for (int p = 0; p < 50; p++) begin
            sender_idle   = $urandom_range(0, 3) != 0;
            receiver_idle = $urandom_range(0, 3) != 0;
            for (int k = 0; k < 8; k++) begin
                case ($urandom_range(0, 3))
                    0: pool[k] = $urandom;
                    1: pool[k] = $urandom_range(0, 15);
                    2: pool[k] = -$urandom_range(1, 16);
                    default: pool[k] = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
                endcase
            end
            n_loads  = $urandom_range(0, 10);
            n_probes = $urandom_range(1, 11);
            for (int i = 0; i < n_loads; i++) begin
                value = ($urandom_range(0, 7) == 0) ? $urandom : pool[$urandom_range(0, 7)];
                // A last flag on a load is noise the block must ignore.
                send_request(OP_LOAD, value, $urandom_range(0, 3) == 0);
            end
            for (int i = 0; i < n_probes; i++) begin
                value = ($urandom_range(0, 7) == 0) ? $urandom : pool[$urandom_range(0, 7)];
                if (i < n_probes - 1 && $urandom_range(0, 5) == 0)
                    send_request(OP_LOAD, value, 1'b0);
                else
                    send_request(OP_PROBE, value, i == n_probes - 1);
            end
        end
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
    endtask

    // Sequence of tests.
    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_op           = OP_LOAD;
        i_value        = '0;
        i_last         = 1'b0;
        list_count     = 0;
        common_count   = 0;
        mismatch_count = 0;
        sender_idle    = 1'b1;
        receiver_idle  = 1'b1;
        recv_wait      = 0;
        hold_request   = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_full_stores();
        test_backpressure();
        test_random();

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
